@@ src/rvdec_pkg.sv @@
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and encodings for the RV32IM/Zicsr instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rvdec_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_OP_IMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_JAL     = 7'h6f;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_MISCMEM = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;
  localparam logic [11:0] SYS_MRET   = 12'h302;

  localparam logic [31:0] UIMM_MASK = 32'hffff_f000;

  // Instruction classes
  localparam logic [3:0] KIND_ILLEGAL = 4'd0;
  localparam logic [3:0] KIND_ALU     = 4'd1;
  localparam logic [3:0] KIND_MULDIV  = 4'd2;
  localparam logic [3:0] KIND_LOAD    = 4'd3;
  localparam logic [3:0] KIND_STORE   = 4'd4;
  localparam logic [3:0] KIND_BRANCH  = 4'd5;
  localparam logic [3:0] KIND_JAL     = 4'd6;
  localparam logic [3:0] KIND_JALR    = 4'd7;
  localparam logic [3:0] KIND_LUI     = 4'd8;
  localparam logic [3:0] KIND_AUIPC   = 4'd9;
  localparam logic [3:0] KIND_FENCE   = 4'd10;
  localparam logic [3:0] KIND_ECALL   = 4'd11;
  localparam logic [3:0] KIND_EBREAK  = 4'd12;
  localparam logic [3:0] KIND_MRET    = 4'd13;
  localparam logic [3:0] KIND_CSR     = 4'd14;

  // ALU operations
  localparam logic [3:0] ALU_ADD  = 4'd0;
  localparam logic [3:0] ALU_SUB  = 4'd1;
  localparam logic [3:0] ALU_SLL  = 4'd2;
  localparam logic [3:0] ALU_SLT  = 4'd3;
  localparam logic [3:0] ALU_SLTU = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_SRL  = 4'd6;
  localparam logic [3:0] ALU_SRA  = 4'd7;
  localparam logic [3:0] ALU_OR   = 4'd8;
  localparam logic [3:0] ALU_AND  = 4'd9;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_PRIV   = 3'd0;
  localparam logic [2:0] F3_CSR_NA = 3'd4;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Decoded record as held in the result register
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [11:0] csr_address;
    logic [31:0] immediate;
    logic        reads_src1;
    logic        reads_src2;
    logic        writes_dest;
    logic [1:0]  access_size;
    logic        access_unsigned;
  } dec_t;

  function automatic logic [3:0] alu_op_of(input logic [2:0] f3);
    logic [3:0] op;
    case (f3)
      F3_ADD:  op = ALU_ADD;
      F3_SLL:  op = ALU_SLL;
      F3_SLT:  op = ALU_SLT;
      F3_SLTU: op = ALU_SLTU;
      F3_XOR:  op = ALU_XOR;
      F3_SR:   op = ALU_SRL;
      F3_OR:   op = ALU_OR;
      F3_AND:  op = ALU_AND;
      default: op = ALU_ADD;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

@@ src/rv32im_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// RV32IM + Zicsr decoder: instruction word in, decoded record out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | instr_word, is_full_width
//  out_    | output    | out_valid/out_stall | decoded record (12 fields)
//
//  Two register stages: the input register, then the decode logic feeding the
//  result register. Throughput is 1 transfer per cycle while out_stall is low.
//  rst_n (synchronous) clears both valid bits; payload registers are not reset.
//  out_stall backs up into in_stall only when both stages hold an item.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32im_instruction_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_instr_word,
  input  wire logic               in_is_full_width,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              out_kind,
  output logic [3:0]              out_operation,
  output logic [4:0]              out_dest_reg,
  output logic [4:0]              out_src1_reg,
  output logic [4:0]              out_src2_reg,
  output logic [11:0]             out_csr_address,
  output logic signed [31:0]      out_immediate,
  output logic                    out_reads_src1,
  output logic                    out_reads_src2,
  output logic                    out_writes_dest,
  output logic [1:0]              out_access_size,
  output logic                    out_access_unsigned
);

  logic              s1_valid_r;
  logic [31:0]       s1_word_r;
  logic              s1_full_r;
  logic              out_valid_r;
  rvdec_pkg::dec_t   dec_r;
  rvdec_pkg::dec_t   dec_nxt;
  logic              out_adv;
  logic              s1_load;

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_instr_word;
      s1_full_r <= in_is_full_width;
    end
    if (out_adv && s1_valid_r) begin
      dec_r <= dec_nxt;
    end
  end

  // Decode
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [11:0] sys_field;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_sh;
  logic [3:0]  kind;
  logic [3:0]  op;
  logic [31:0] imm;
  logic [1:0]  size;
  logic        r1;
  logic        r2;
  logic        wr;
  logic        uns;
  logic        bad;
  logic        give_rs1;
  logic        is_csr;

  assign opc       = s1_word_r[6:0];
  assign f3        = s1_word_r[14:12];
  assign f7        = s1_word_r[31:25];
  assign sys_field = s1_word_r[31:20];
  assign imm_i     = {{20{s1_word_r[31]}}, s1_word_r[31:20]};
  assign imm_s     = {{20{s1_word_r[31]}}, s1_word_r[31:25], s1_word_r[11:7]};
  assign imm_b     = {{20{s1_word_r[31]}}, s1_word_r[7], s1_word_r[30:25],
                      s1_word_r[11:8], 1'b0};
  assign imm_j     = {{12{s1_word_r[31]}}, s1_word_r[19:12], s1_word_r[20],
                      s1_word_r[30:21], 1'b0};
  assign imm_sh    = {27'd0, s1_word_r[24:20]};

  always_comb begin
    kind     = rvdec_pkg::KIND_ILLEGAL;
    op       = 4'd0;
    imm      = 32'd0;
    size     = rvdec_pkg::SIZE_BYTE;
    r1       = 1'b0;
    r2       = 1'b0;
    wr       = 1'b0;
    uns      = 1'b0;
    bad      = 1'b0;
    give_rs1 = 1'b0;
    is_csr   = 1'b0;
    case (opc)
      rvdec_pkg::OPC_OP: begin
        r1 = 1'b1;
        r2 = 1'b1;
        wr = 1'b1;
        if (f7 == rvdec_pkg::F7_MULDIV) begin
          kind = rvdec_pkg::KIND_MULDIV;
          op   = {1'b0, f3};
        end else begin
          kind = rvdec_pkg::KIND_ALU;
          op   = rvdec_pkg::alu_op_of(f3);
          if (f3 == rvdec_pkg::F3_ADD || f3 == rvdec_pkg::F3_SR) begin
            // funct7 0x20 selects SUB / SRA, one code above ADD / SRL
            if (f7 == rvdec_pkg::F7_ALT) begin
              op = op + 4'd1;
            end else if (f7 != rvdec_pkg::F7_BASE) begin
              bad = 1'b1;
            end
          end else begin
            bad = (f7 != rvdec_pkg::F7_BASE);
          end
        end
      end
      rvdec_pkg::OPC_OP_IMM: begin
        kind = rvdec_pkg::KIND_ALU;
        r1   = 1'b1;
        wr   = 1'b1;
        imm  = imm_i;
        op   = rvdec_pkg::alu_op_of(f3);
        if (f3 == rvdec_pkg::F3_SLL) begin
          imm = imm_sh;
          bad = (f7 != rvdec_pkg::F7_BASE);
        end else if (f3 == rvdec_pkg::F3_SR) begin
          imm = imm_sh;
          if (f7 == rvdec_pkg::F7_ALT) begin
            op = rvdec_pkg::ALU_SRA;
          end else begin
            bad = (f7 != rvdec_pkg::F7_BASE);
          end
        end
      end
      rvdec_pkg::OPC_LOAD: begin
        kind = rvdec_pkg::KIND_LOAD;
        r1   = 1'b1;
        wr   = 1'b1;
        imm  = imm_i;
        bad  = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
        size = f3[1:0];
        uns  = f3[2];
      end
      rvdec_pkg::OPC_STORE: begin
        kind = rvdec_pkg::KIND_STORE;
        r1   = 1'b1;
        r2   = 1'b1;
        imm  = imm_s;
        bad  = (f3 > 3'd2);
        size = f3[1:0];
      end
      rvdec_pkg::OPC_BRANCH: begin
        kind = rvdec_pkg::KIND_BRANCH;
        r1   = 1'b1;
        r2   = 1'b1;
        imm  = imm_b;
        // funct3 2 and 3 are unused; the upper four map down by two
        bad  = (f3 == 3'd2) || (f3 == 3'd3);
        op   = f3[2] ? {1'b0, f3} - 4'd2 : {1'b0, f3};
      end
      rvdec_pkg::OPC_JAL: begin
        kind = rvdec_pkg::KIND_JAL;
        wr   = 1'b1;
        imm  = imm_j;
      end
      rvdec_pkg::OPC_JALR: begin
        kind = rvdec_pkg::KIND_JALR;
        r1   = 1'b1;
        wr   = 1'b1;
        imm  = imm_i;
        bad  = (f3 != 3'd0);
      end
      rvdec_pkg::OPC_LUI: begin
        kind = rvdec_pkg::KIND_LUI;
        wr   = 1'b1;
        imm  = s1_word_r & rvdec_pkg::UIMM_MASK;
      end
      rvdec_pkg::OPC_AUIPC: begin
        kind = rvdec_pkg::KIND_AUIPC;
        wr   = 1'b1;
        imm  = s1_word_r & rvdec_pkg::UIMM_MASK;
      end
      rvdec_pkg::OPC_MISCMEM: begin
        kind = rvdec_pkg::KIND_FENCE;
        bad  = (f3 > 3'd1);
      end
      rvdec_pkg::OPC_SYSTEM: begin
        if (f3 == rvdec_pkg::F3_PRIV) begin
          if (s1_word_r[11:7] != 5'd0 || s1_word_r[19:15] != 5'd0) begin
            bad = 1'b1;
          end else if (sys_field == rvdec_pkg::SYS_ECALL) begin
            kind = rvdec_pkg::KIND_ECALL;
          end else if (sys_field == rvdec_pkg::SYS_EBREAK) begin
            kind = rvdec_pkg::KIND_EBREAK;
          end else if (sys_field == rvdec_pkg::SYS_MRET) begin
            kind = rvdec_pkg::KIND_MRET;
          end else begin
            bad = 1'b1;
          end
        end else if (f3 == rvdec_pkg::F3_CSR_NA) begin
          bad = 1'b1;
        end else begin
          kind     = rvdec_pkg::KIND_CSR;
          wr       = 1'b1;
          r1       = !f3[2];
          give_rs1 = 1'b1;   // uimm forms still pass bits 19..15
          is_csr   = 1'b1;
          op       = f3[2] ? {1'b0, f3} - 4'd2 : {1'b0, f3} - 4'd1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    dec_nxt = '0;
    if (s1_full_r && !bad) begin
      dec_nxt.kind            = kind;
      dec_nxt.operation       = op;
      dec_nxt.dest_reg        = wr ? s1_word_r[11:7] : 5'd0;
      dec_nxt.src1_reg        = (r1 || give_rs1) ? s1_word_r[19:15] : 5'd0;
      dec_nxt.src2_reg        = r2 ? s1_word_r[24:20] : 5'd0;
      dec_nxt.csr_address     = is_csr ? sys_field : 12'd0;
      dec_nxt.immediate       = imm;
      dec_nxt.reads_src1      = r1;
      dec_nxt.reads_src2      = r2;
      dec_nxt.writes_dest     = wr;
      dec_nxt.access_size     = size;
      dec_nxt.access_unsigned = uns;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = dec_r.kind;
  assign out_operation       = dec_r.operation;
  assign out_dest_reg        = dec_r.dest_reg;
  assign out_src1_reg        = dec_r.src1_reg;
  assign out_src2_reg        = dec_r.src2_reg;
  assign out_csr_address     = dec_r.csr_address;
  assign out_immediate       = $signed(dec_r.immediate);
  assign out_reads_src1      = dec_r.reads_src1;
  assign out_reads_src2      = dec_r.reads_src2;
  assign out_writes_dest     = dec_r.writes_dest;
  assign out_access_size     = dec_r.access_size;
  assign out_access_unsigned = dec_r.access_unsigned;

endmodule

`default_nettype wire

@@ src/rvdec_checker.sv @@
// ----------------------------------------------------------------------------
// rvdec_checker
// Port-level checks for the instruction decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rvdec_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [3:0]         out_kind,
  input wire logic [4:0]         out_dest_reg,
  input wire logic [11:0]        out_csr_address,
  input wire logic signed [31:0] out_immediate,
  input wire logic               out_reads_src1,
  input wire logic               out_reads_src2,
  input wire logic               out_writes_dest,
  input wire logic [1:0]         out_access_size
);

  // A stalled result transfer stays valid and keeps its kind and immediate
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_immediate))
    else $error("stalled result changed");

  // Illegal decode leaves every enable and the immediate clear
  a_illegal_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rvdec_pkg::KIND_ILLEGAL |->
      !out_reads_src1 && !out_reads_src2 && !out_writes_dest && out_immediate == 32'sd0)
    else $error("illegal decode with live fields");

  // Access size only for memory instructions
  a_size_mem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_access_size != 2'd0 |->
      out_kind == rvdec_pkg::KIND_LOAD || out_kind == rvdec_pkg::KIND_STORE)
    else $error("access size on non-memory instruction");

  // rd index only when rd is written, CSR address only for CSR class
  a_rd_csr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_writes_dest || out_dest_reg == 5'd0) &&
      (out_kind == rvdec_pkg::KIND_CSR || out_csr_address == 12'd0))
    else $error("unused field not zero");

endmodule

bind rv32im_instruction_decoder rvdec_checker u_rvdec_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_dest_reg    (out_dest_reg),
  .out_csr_address (out_csr_address),
  .out_immediate   (out_immediate),
  .out_reads_src1  (out_reads_src1),
  .out_reads_src2  (out_reads_src2),
  .out_writes_dest (out_writes_dest),
  .out_access_size (out_access_size)
);

`default_nettype wire
